FILE: src/cse_pkg.sv
package cse_pkg;

  // frame store
  localparam int MAX_BYTES = 64;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BYTE_W    = 8;

  // register widths
  localparam int POS_W    = 9;
  localparam int BIDX_W   = POS_W - 3;
  localparam int LEN_W    = 7;
  localparam int FAC_W    = 32;
  localparam int OFF_W    = 48;
  localparam int CFG_W    = 48;
  localparam int REG_IDX_W = 3;

  // datapath widths
  localparam int RAW_W   = 64;
  localparam int SIZE_W  = 4;
  localparam int STEPS   = RAW_W / BYTE_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int HI_W    = 42;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MSB_BIT       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LSB_BIT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNAL_BITS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LITTLE_ENDIAN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIGNED_MODE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_OFFSET  = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0]        msb_bit;
    logic [POS_W-1:0]        lsb_bit;
    logic [LEN_W-1:0]        signal_bits;
    logic                    little_endian;
    logic                    signed_mode;
    logic signed [FAC_W-1:0] scale_factor;
    logic signed [OFF_W-1:0] scale_offset;
  } cse_cfg_t;

  // low n bits set, n from 0 to 8
  function automatic logic [BYTE_W-1:0] lo_mask(input logic [SIZE_W-1:0] n);
    logic [BYTE_W:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[BYTE_W-1:0];
  endfunction

endpackage

FILE: src/can_signal_extract.sv
// CAN signal decoder. Payload bytes are taken one a cycle while busy is low;
// a byte with in_last_byte set ends the frame and starts extraction, and busy
// stays high until the result has been shown. Extraction walks the payload
// RAM a byte at a time through a fetch and a slice state (registered read),
// shifts the word into place a byte per cycle, then a byte-serial multiplier
// takes eight steps plus one correction step. A 64-bit signal may be spread
// over nine bytes. The next byte can be taken once busy has fallen. The
// result is marked by out_valid for exactly one cycle; the receiver cannot
// stall and must take it then. Bytes past the 64th are dropped.
// The user must write configuration only while the block is idle; the block
// itself does not enforce it.
module can_signal_extract import cse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [BYTE_W-1:0]       in_payload_byte,
  input  logic                    in_last_byte,
  output logic                    out_valid,
  output logic [RAW_W-1:0]        out_raw_bits,
  output logic signed [RAW_W-1:0] out_scaled_value,
  output logic                    out_saturated,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {T_IDLE, T_WALK, T_MUL} state_t;

  state_t           state_r;
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             walk_go_r;
  logic             mul_go_r;
  cse_cfg_t         cfg_r;

  logic               accept;
  logic               room;
  logic [BYTE_W-1:0]  rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               walk_done;
  logic [RAW_W-1:0]   walk_raw;
  logic               mul_done;
  logic [RAW_W-1:0]   mul_scaled;
  logic               mul_sat;

  assign accept = start && !busy_r;
  assign room   = 8'(cnt_r) < 8'(MAX_BYTES);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.msb_bit       <= POS_W'(7);
      cfg_r.lsb_bit       <= '0;
      cfg_r.signal_bits   <= LEN_W'(8);
      cfg_r.little_endian <= 1'b0;
      cfg_r.signed_mode   <= 1'b0;
      cfg_r.scale_factor  <= FAC_W'(65536);
      cfg_r.scale_offset  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MSB_BIT:       cfg_r.msb_bit       <= cfg_data[POS_W-1:0];
        REG_LSB_BIT:       cfg_r.lsb_bit       <= cfg_data[POS_W-1:0];
        REG_SIGNAL_BITS:   cfg_r.signal_bits   <= cfg_data[LEN_W-1:0];
        REG_LITTLE_ENDIAN: cfg_r.little_endian <= cfg_data[0];
        REG_SIGNED_MODE:   cfg_r.signed_mode   <= cfg_data[0];
        REG_SCALE_FACTOR:  cfg_r.scale_factor  <= cfg_data[FAC_W-1:0];
        REG_SCALE_OFFSET:  cfg_r.scale_offset  <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // frame sequencer: load, walk, scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= T_IDLE;
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      walk_go_r <= 1'b0;
      mul_go_r  <= 1'b0;
    end else begin
      walk_go_r <= 1'b0;
      mul_go_r  <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (room) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            if (in_last_byte) begin
              walk_go_r <= 1'b1;
              busy_r    <= 1'b1;
              state_r   <= T_WALK;
            end
          end
        end
        T_WALK: begin
          if (walk_done) begin
            mul_go_r <= 1'b1;
            state_r  <= T_MUL;
          end
        end
        T_MUL: begin
          if (mul_done) begin
            busy_r  <= 1'b0;
            cnt_r   <= '0;
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // payload store
  cse_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (accept && room),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_payload_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  // bit extraction
  cse_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (walk_go_r),
    .cfg         (cfg_r),
    .bytes_loaded(cnt_r),
    .rdata       (rdata),
    .raddr       (raddr),
    .done        (walk_done),
    .raw         (walk_raw)
  );

  // scaling
  cse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .cfg   (cfg_r),
    .raw   (walk_raw),
    .done  (mul_done),
    .scaled(mul_scaled),
    .sat   (mul_sat)
  );

  assign busy             = busy_r;
  assign out_valid        = mul_done;
  assign out_raw_bits     = walk_raw;
  assign out_scaled_value = mul_scaled;
  assign out_saturated    = mul_sat;

endmodule

FILE: src/cse_ram.sv
module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cse_walk.sv
module cse_walk import cse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  cse_cfg_t          cfg,
  input  logic [CNT_W-1:0]  bytes_loaded,
  input  logic [BYTE_W-1:0] rdata,
  output logic [ADDR_W-1:0] raddr,
  output logic              done,
  output logic [RAW_W-1:0]  raw
);

  typedef enum logic [1:0] {W_IDLE, W_FETCH, W_SLICE, W_TAIL} state_t;

  state_t              state_r;
  logic [BIDX_W-1:0]   idx_r;
  logic [LEN_W-1:0]    bits_r;
  logic [RAW_W-1:0]    acc_r;
  logic                first_r;
  logic                done_r;

  logic [BIDX_W-1:0]   msb_byte;
  logic [LEN_W-1:0]    len_clip;
  logic                start_ok;
  logic [2:0]          lo_sel;
  logic [2:0]          hi_sel;
  logic [SIZE_W-1:0]   size_raw;
  logic [SIZE_W-1:0]   size;
  logic [BYTE_W-1:0]   d0;
  logic [BYTE_W-1:0]   d1;
  logic                sbit;
  logic [RAW_W-1:0]    ext;
  logic [RAW_W-1:0]    appended;
  logic [LEN_W-1:0]    bits_after;
  logic [BIDX_W-1:0]   idx_next;
  logic                more;
  logic [SIZE_W-1:0]   tail_n;

  assign msb_byte = cfg.msb_bit[POS_W-1:3];
  assign len_clip = (cfg.signal_bits > LEN_W'(RAW_W)) ? LEN_W'(RAW_W) : cfg.signal_bits;
  assign start_ok = (8'(msb_byte) < 8'(bytes_loaded)) && (len_clip != '0);

  // bit slice of the current byte
  always_comb begin
    lo_sel   = (cfg.lsb_bit[POS_W-1:3] == idx_r) ? cfg.lsb_bit[2:0] : 3'd0;
    hi_sel   = (msb_byte == idx_r) ? cfg.msb_bit[2:0] : 3'd7;
    size_raw = SIZE_W'({1'b0, hi_sel}) - SIZE_W'({1'b0, lo_sel}) + SIZE_W'(1);
    d0       = (rdata >> lo_sel) & lo_mask(size_raw);
    if (hi_sel < lo_sel) begin
      d1   = '0;
      size = '0;
    end else if (LEN_W'(size_raw) > bits_r) begin
      d1   = d0 >> (size_raw - bits_r[SIZE_W-1:0]);
      size = bits_r[SIZE_W-1:0];
    end else begin
      d1   = d0;
      size = size_raw;
    end
  end

  // first slice carries the sign in signed mode
  always_comb begin
    sbit = (size != '0) && ((d1 & (8'd1 << (size - SIZE_W'(1)))) != '0);
    ext  = {{(RAW_W-BYTE_W){1'b0}}, d1};
    if (cfg.signed_mode && first_r && sbit) begin
      ext = ext | ~{{(RAW_W-BYTE_W){1'b0}}, lo_mask(size)};
    end
    appended   = (acc_r << size) | ext;
    bits_after = bits_r - LEN_W'(size);
  end

  // next byte index and range check
  always_comb begin
    if (cfg.little_endian) begin
      idx_next = idx_r - BIDX_W'(1);
      more     = (idx_r != '0);
    end else begin
      idx_next = idx_r + BIDX_W'(1);
      more     = (8'(idx_r) + 8'd1) < 8'(bytes_loaded);
    end
  end

  assign tail_n = (bits_r >= LEN_W'(BYTE_W)) ? SIZE_W'(BYTE_W) : bits_r[SIZE_W-1:0];

  // walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      done_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        W_IDLE: begin
          if (go) begin
            idx_r   <= msb_byte;
            bits_r  <= len_clip;
            acc_r   <= '0;
            first_r <= 1'b1;
            state_r <= start_ok ? W_FETCH : W_TAIL;
          end
        end
        W_FETCH: begin
          state_r <= W_SLICE;
        end
        W_SLICE: begin
          acc_r  <= appended;
          bits_r <= bits_after;
          idx_r  <= idx_next;
          if (size != '0) begin
            first_r <= 1'b0;
          end
          state_r <= (more && bits_after != '0) ? W_FETCH : W_TAIL;
        end
        W_TAIL: begin
          if (bits_r == '0) begin
            done_r  <= 1'b1;
            state_r <= W_IDLE;
          end else begin
            acc_r  <= acc_r << tail_n;
            bits_r <= bits_r - LEN_W'(tail_n);
          end
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign raddr = idx_r[ADDR_W-1:0];
  assign done  = done_r;
  assign raw   = acc_r;

endmodule

FILE: src/cse_mul.sv
module cse_mul import cse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  cse_cfg_t         cfg,
  input  logic [RAW_W-1:0] raw,
  output logic             done,
  output logic [RAW_W-1:0] scaled,
  output logic             sat
);

  typedef enum logic [1:0] {M_IDLE, M_STEP, M_FIX} state_t;

  state_t                   state_r;
  logic [STEP_W-1:0]        cnt_r;
  logic [RAW_W-1:0]         rsh_r;
  logic                     rneg_r;
  logic signed [HI_W-1:0]   acc_r;
  logic signed [OFF_W-1:0]  off_r;
  logic [RAW_W-1:0]         lo_r;
  logic                     done_r;
  logic [RAW_W-1:0]         scaled_r;
  logic                     sat_r;

  logic signed [FAC_W+BYTE_W:0] prod;
  logic signed [HI_W-1:0]       sum;
  logic signed [HI_W-1:0]       hi;
  logic                         fits;

  // one byte of raw times the factor, offset folded in a byte at a time
  always_comb begin
    prod = $signed({1'b0, rsh_r[BYTE_W-1:0]}) * cfg.scale_factor;
    sum  = acc_r + HI_W'(prod) + $signed({{(HI_W-BYTE_W){1'b0}}, off_r[BYTE_W-1:0]});
  end

  // upper word: signed correction and the offset's sign bits
  always_comb begin
    hi = acc_r - (rneg_r ? HI_W'(cfg.scale_factor) : HI_W'(0)) + HI_W'(off_r);
    fits = ((hi == '0) && !lo_r[RAW_W-1]) || ((hi == '1) && lo_r[RAW_W-1]);
  end

  // multiply sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (go) begin
            rsh_r   <= raw;
            rneg_r  <= cfg.signed_mode & raw[RAW_W-1];
            acc_r   <= '0;
            off_r   <= cfg.scale_offset;
            cnt_r   <= '0;
            state_r <= M_STEP;
          end
        end
        M_STEP: begin
          lo_r  <= {sum[BYTE_W-1:0], lo_r[RAW_W-1:BYTE_W]};
          acc_r <= sum >>> BYTE_W;
          off_r <= off_r >>> BYTE_W;
          rsh_r <= rsh_r >> BYTE_W;
          cnt_r <= cnt_r + STEP_W'(1);
          if (cnt_r == STEP_W'(STEPS - 1)) begin
            state_r <= M_FIX;
          end
        end
        M_FIX: begin
          sat_r <= !fits;
          if (fits) begin
            scaled_r <= lo_r;
          end else if (hi[HI_W-1]) begin
            scaled_r <= {1'b1, {(RAW_W-1){1'b0}}};
          end else begin
            scaled_r <= {1'b0, {(RAW_W-1){1'b1}}};
          end
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign scaled = scaled_r;
  assign sat    = sat_r;

endmodule
